### rtl/core/cpmi_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpmi_pkg
// Shared widths and constants for the column pair mutual information core.
// ----------------------------------------------------------------------------
package cpmi_pkg;

  // beat field widths
  localparam int SYM_W = 5;
  localparam int CFG_W = 6;
  localparam int OUT_W = 32;

  // alphabet size after reset
  localparam logic [CFG_W-1:0] ALPHA_RESET = 6'd27;

  // log2 format q5.28
  localparam int FRAC_BITS = 28;
  localparam int LOG_W     = 33;

  // shared multiplier operand and product widths
  localparam int MUL_W  = 32;
  localparam int PROD_W = 64;

  // accumulator, scaled numerator and denominator widths
  localparam int ACC_W = 50;
  localparam int NUM_W = 66;
  localparam int DEN_W = 32;

  // ln 2 in q28
  localparam logic [FRAC_BITS-1:0] LN2_Q28 = 28'd186065280;

endpackage

### rtl/core/cpmi_row_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpmi_row_if
// Row channel: one symbol pair of the two columns per beat.
// ----------------------------------------------------------------------------
interface cpmi_row_if;
  import cpmi_pkg::*;

  logic             valid;
  logic             ready;
  logic [SYM_W-1:0] sym_x;
  logic [SYM_W-1:0] sym_y;
  logic             last_row;

  modport source (output valid, sym_x, sym_y, last_row, input ready);
  modport sink   (input valid, sym_x, sym_y, last_row, output ready);
endinterface

### rtl/core/cpmi_res_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpmi_res_if
// Result channel: mutual information value and degenerate flag per beat.
// ----------------------------------------------------------------------------
interface cpmi_res_if;
  import cpmi_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] mi_value;
  logic                    degenerate;

  modport source (output valid, mi_value, degenerate, input ready);
  modport sink   (input valid, mi_value, degenerate, output ready);
endinterface

### rtl/core/cpmi_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpmi_ram
// Generic single write port, single read port ram with registered read.
// ----------------------------------------------------------------------------
module cpmi_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/core/cpmi_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpmi_mul
// Shared unsigned multiplier with a registered product.
// ----------------------------------------------------------------------------
module cpmi_mul (
  input  logic                         clk,
  input  logic [cpmi_pkg::MUL_W-1:0]  a,
  input  logic [cpmi_pkg::MUL_W-1:0]  b,
  output logic [cpmi_pkg::PROD_W-1:0] p
);
  import cpmi_pkg::*;

  // one product per cycle, registered
  always_ff @(posedge clk) begin
    p <= PROD_W'(a) * PROD_W'(b);
  end

endmodule

### rtl/core/cpmi_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpmi_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module cpmi_div #(
  parameter int NUM_W = 66,
  parameter int DEN_W = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quo
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [DEN_W-1:0] rem;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic [DEN_W:0]   rem_sh;
  logic [DEN_W+1:0] diff;

  // trial subtract of the shifted remainder
  assign rem_sh = {rem, quo[NUM_W-1]};
  assign diff   = {1'b0, rem_sh} - {2'b00, den};

  // quotient shifts in from the bottom as the dividend shifts out the top
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        quo  <= num;
        rem  <= '0;
        cnt  <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        if (diff[DEN_W+1]) begin
          rem <= rem_sh[DEN_W-1:0];
          quo <= {quo[NUM_W-2:0], 1'b0};
        end else begin
          rem <= diff[DEN_W-1:0];
          quo <= {quo[NUM_W-2:0], 1'b1};
        end
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(NUM_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

### rtl/core/column_pair_mutual_information_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// column_pair_mutual_information_core
// Counts joint and per-column symbol histograms of a column pair and, on the
// last row, emits the gap-weighted mutual information in signed q8.24 nats.
// ----------------------------------------------------------------------------
//  channel | dir | payload                          | handshake
//  row     | in  | sym_x, sym_y, last_row           | valid / ready
//  res     | out | mi_value, degenerate             | valid / ready
//  cfg     | in  | cfg_wdata (alphabet_size)        | cfg_we, no stall
//
//  a row steps through accept, ram read, ram read-modify-write increment
//  the last row then walks (min(alphabet_size, SYMBOL_SLOTS)-1)^2 pair
//  entries; each nonzero entry runs two 28-round log2 squarings on the
//  shared multiplier; final scaling runs the divider
//  after reset and after every result a clearing pass over SYMBOL_SLOTS^2
//  pair entries runs with row.ready low; a held result blocks further rows
// ----------------------------------------------------------------------------
module column_pair_mutual_information_core #(
  parameter int MAX_ROWS     = 16384,
  parameter int SYMBOL_SLOTS = 32
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [cpmi_pkg::CFG_W-1:0] cfg_wdata,
  cpmi_row_if.sink                   row,
  cpmi_res_if.source                 res
);
  import cpmi_pkg::*;

  localparam int CNT_W      = $clog2(MAX_ROWS + 1);
  localparam int SLOT_W     = $clog2(SYMBOL_SLOTS);
  localparam int PAIR_DEPTH = SYMBOL_SLOTS * SYMBOL_SLOTS;
  localparam int PAIR_AW    = $clog2(PAIR_DEPTH);
  localparam int LIM_W      = 7;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_LD_RD, S_LD_WR, S_PRE, S_DEN, S_DEN_T,
    S_T_RD, S_T_CHK, S_LV_T, S_NORM, S_SQ_MUL, S_SQ_UPD, S_LV2_MUL,
    S_CD_LO, S_CD_ACC, S_CD_HI, S_NEXT, S_FIN, S_FIN_HI, S_FIN_LO,
    S_DIV_GO, S_DIV, S_SC_LO, S_SC_MID, S_SC_HI, S_RES, S_OUT
  } state_t;

  state_t                  state;
  logic [CFG_W-1:0]        alpha;
  logic [SYM_W-1:0]        sx_r;
  logic [SYM_W-1:0]        sy_r;
  logic                    last_r;
  logic [CNT_W-1:0]        row_total;
  logic [CNT_W-1:0]        gx;
  logic [CNT_W-1:0]        gy;
  logic [PAIR_AW-1:0]      clr_addr;
  logic [SLOT_W-1:0]       ex;
  logic [SLOT_W-1:0]       ey;
  logic [CNT_W-1:0]        c_r;
  logic [CNT_W-1:0]        cx_r;
  logic [CNT_W-1:0]        cy_r;
  logic [30:0]             m;
  logic [4:0]              k;
  logic [2:0]              step;
  logic [4:0]              rnd;
  logic [FRAC_BITS-1:0]    frac;
  logic                    which;
  logic [LOG_W-1:0]        l1;
  logic                    dneg;
  logic [LOG_W:0]          dabs;
  logic signed [ACC_W-1:0] acc;
  logic [NUM_W-1:0]        num;
  logic [NUM_W-1:0]        sc;
  logic [DEN_W-1:0]        den;
  logic signed [OUT_W-1:0] mi_out;
  logic                    deg_out;

  logic [CNT_W-1:0]   nx;
  logic [CNT_W-1:0]   ny;
  logic               x_in;
  logic               y_in;
  logic               room;
  logic [LIM_W-1:0]   lim;
  logic [SLOT_W-1:0]  lim_m1;
  logic [PAIR_AW-1:0] pair_ld_addr;
  logic [PAIR_AW-1:0] pair_t_addr;
  logic               clr;
  logic               ld_wr;
  logic               re;
  logic               f_we;
  logic               s_we;
  logic               p_we;
  logic [SLOT_W-1:0]  f_waddr;
  logic [SLOT_W-1:0]  s_waddr;
  logic [PAIR_AW-1:0] p_waddr;
  logic [CNT_W-1:0]   f_wdata;
  logic [CNT_W-1:0]   s_wdata;
  logic [CNT_W-1:0]   p_wdata;
  logic [SLOT_W-1:0]  f_raddr;
  logic [SLOT_W-1:0]  s_raddr;
  logic [PAIR_AW-1:0] p_raddr;
  logic [CNT_W-1:0]   f_rdata;
  logic [CNT_W-1:0]   s_rdata;
  logic [CNT_W-1:0]   p_rdata;
  logic [MUL_W-1:0]   mul_a;
  logic [MUL_W-1:0]   mul_b;
  logic [PROD_W-1:0]  p;
  logic [ACC_W-1:0]   mag_c;
  logic [4:0]         sh;
  logic               top_zero;
  logic [31:0]        sq_t;
  logic               sq_bit;
  logic [LOG_W-1:0]   log_val;
  logic [LOG_W:0]     d_c;
  logic               div_start;
  logic               div_done;
  logic [NUM_W-1:0]   div_quo;
  logic [33:0]        r;
  logic [33:0]        r_sat;
  logic [OUT_W-1:0]   res_val;

  // row counts and range checks
  assign nx     = row_total - gx;
  assign ny     = row_total - gy;
  assign x_in   = 32'(sx_r) < SYMBOL_SLOTS;
  assign y_in   = 32'(sy_r) < SYMBOL_SLOTS;
  assign room   = 32'(row_total) < MAX_ROWS;
  assign lim    = (LIM_W'(alpha) < LIM_W'(SYMBOL_SLOTS)) ? LIM_W'(alpha)
                                                        : LIM_W'(SYMBOL_SLOTS);
  assign lim_m1 = SLOT_W'(lim - 7'd1);

  // histogram addresses
  assign pair_ld_addr = PAIR_AW'(PAIR_AW'(sx_r) * PAIR_AW'(SYMBOL_SLOTS) + PAIR_AW'(sy_r));
  assign pair_t_addr  = PAIR_AW'(PAIR_AW'(ex) * PAIR_AW'(SYMBOL_SLOTS) + PAIR_AW'(ey));

  assign clr   = (state == S_CLEAR);
  assign ld_wr = (state == S_LD_WR);
  assign re    = (state == S_LD_RD) || (state == S_T_RD);

  assign f_raddr = (state == S_LD_RD) ? SLOT_W'(sx_r) : ex;
  assign s_raddr = (state == S_LD_RD) ? SLOT_W'(sy_r) : ey;
  assign p_raddr = (state == S_LD_RD) ? pair_ld_addr : pair_t_addr;

  // clearing sweep or increment write-back
  assign f_we    = (clr && (32'(clr_addr) < SYMBOL_SLOTS)) || (ld_wr && x_in);
  assign s_we    = (clr && (32'(clr_addr) < SYMBOL_SLOTS)) || (ld_wr && y_in);
  assign p_we    = clr || (ld_wr && x_in && y_in);
  assign f_waddr = clr ? SLOT_W'(clr_addr) : SLOT_W'(sx_r);
  assign s_waddr = clr ? SLOT_W'(clr_addr) : SLOT_W'(sy_r);
  assign p_waddr = clr ? clr_addr : pair_ld_addr;
  assign f_wdata = clr ? '0 : f_rdata + 1'b1;
  assign s_wdata = clr ? '0 : s_rdata + 1'b1;
  assign p_wdata = clr ? '0 : p_rdata + 1'b1;

  cpmi_ram #(.WIDTH(CNT_W), .DEPTH(SYMBOL_SLOTS)) u_first_ram (
    .clk(clk), .we(f_we), .waddr(f_waddr), .wdata(f_wdata),
    .re(re), .raddr(f_raddr), .rdata(f_rdata)
  );

  cpmi_ram #(.WIDTH(CNT_W), .DEPTH(SYMBOL_SLOTS)) u_second_ram (
    .clk(clk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
    .re(re), .raddr(s_raddr), .rdata(s_rdata)
  );

  cpmi_ram #(.WIDTH(CNT_W), .DEPTH(PAIR_DEPTH)) u_pair_ram (
    .clk(clk), .we(p_we), .waddr(p_waddr), .wdata(p_wdata),
    .re(re), .raddr(p_raddr), .rdata(p_rdata)
  );

  // accumulator magnitude for final scaling
  assign mag_c = acc[ACC_W-1] ? ACC_W'(-acc) : ACC_W'(acc);

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_DEN: begin
        mul_a = MUL_W'(nx);
        mul_b = MUL_W'(ny);
      end
      S_T_CHK: begin
        mul_a = MUL_W'(p_rdata);
        mul_b = MUL_W'(row_total);
      end
      S_LV2_MUL: begin
        mul_a = MUL_W'(cx_r);
        mul_b = MUL_W'(cy_r);
      end
      S_SQ_MUL: begin
        mul_a = MUL_W'(m);
        mul_b = MUL_W'(m);
      end
      S_CD_LO: begin
        mul_a = MUL_W'(c_r);
        mul_b = MUL_W'(dabs[16:0]);
      end
      S_CD_ACC: begin
        mul_a = MUL_W'(c_r);
        mul_b = MUL_W'(dabs[LOG_W:17]);
      end
      S_FIN: begin
        mul_a = MUL_W'(mag_c[ACC_W-1:32]);
        mul_b = MUL_W'(row_total);
      end
      S_FIN_HI: begin
        mul_a = mag_c[31:0];
        mul_b = MUL_W'(row_total);
      end
      S_SC_LO: begin
        mul_a = div_quo[31:0];
        mul_b = MUL_W'(LN2_Q28);
      end
      S_SC_MID: begin
        mul_a = MUL_W'(div_quo[35:32]);
        mul_b = MUL_W'(LN2_Q28);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  cpmi_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p(p));

  assign div_start = (state == S_DIV_GO);

  cpmi_div #(.NUM_W(NUM_W), .DEN_W(DEN_W)) u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(num), .den(den),
    .done(div_done), .quo(div_quo)
  );

  // log2 normalise step: shift by 16, 8, 4, 2, 1 while the top bits are clear
  assign sh       = 5'd16 >> step;
  assign top_zero = (m >> (5'd31 - sh)) == '0;

  // log2 fraction round from the squared mantissa
  assign sq_t    = p[61:30];
  assign sq_bit  = sq_t[31];
  assign log_val = {k, frac[FRAC_BITS-2:0], sq_bit};
  assign d_c     = {1'b0, l1} - {1'b0, log_val};

  // rounding and saturation of the scaled result
  assign r     = sc[NUM_W-1:32];
  assign r_sat = acc[ACC_W-1] ? ((r > 34'h080000000) ? 34'h080000000 : r)
                              : ((r > 34'h07FFFFFFF) ? 34'h07FFFFFFF : r);
  assign res_val = acc[ACC_W-1] ? OUT_W'(34'd0 - r_sat) : r_sat[OUT_W-1:0];

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      alpha     <= ALPHA_RESET;
      clr_addr  <= '0;
      row_total <= '0;
      gx        <= '0;
      gy        <= '0;
    end else begin
      if (cfg_we) begin
        alpha <= cfg_wdata;
      end
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == PAIR_AW'(PAIR_DEPTH - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (row.valid) begin
            sx_r   <= row.sym_x;
            sy_r   <= row.sym_y;
            last_r <= row.last_row;
            state  <= S_LD_RD;
          end
        end
        S_LD_RD: begin
          if (room) begin
            state <= S_LD_WR;
          end else if (last_r) begin
            state <= S_PRE;
          end else begin
            state <= S_IDLE;
          end
        end
        S_LD_WR: begin
          row_total <= row_total + 1'b1;
          if (sx_r == '0) begin
            gx <= gx + 1'b1;
          end
          if (sy_r == '0) begin
            gy <= gy + 1'b1;
          end
          state <= last_r ? S_PRE : S_IDLE;
        end
        S_PRE: begin
          if (nx == '0 || ny == '0) begin
            mi_out  <= '0;
            deg_out <= 1'b1;
            state   <= S_OUT;
          end else begin
            state <= S_DEN;
          end
        end
        S_DEN: begin
          state <= S_DEN_T;
        end
        S_DEN_T: begin
          den   <= p[DEN_W-1:0];
          acc   <= '0;
          ex    <= SLOT_W'(1);
          ey    <= SLOT_W'(1);
          state <= (lim < 7'd2) ? S_FIN : S_T_RD;
        end
        S_T_RD: begin
          state <= S_T_CHK;
        end
        S_T_CHK: begin
          c_r  <= p_rdata;
          cx_r <= f_rdata;
          cy_r <= s_rdata;
          if (p_rdata == '0 || f_rdata == '0 || s_rdata == '0) begin
            state <= S_NEXT;
          end else begin
            which <= 1'b0;
            state <= S_LV_T;
          end
        end
        S_LV_T: begin
          m     <= p[30:0];
          k     <= 5'd30;
          step  <= '0;
          state <= S_NORM;
        end
        S_NORM: begin
          if (top_zero) begin
            m <= m << sh;
            k <= k - sh;
          end
          step <= step + 1'b1;
          if (step == 3'd4) begin
            rnd   <= '0;
            frac  <= '0;
            state <= S_SQ_MUL;
          end
        end
        S_SQ_MUL: begin
          state <= S_SQ_UPD;
        end
        S_SQ_UPD: begin
          m    <= sq_bit ? sq_t[31:1] : sq_t[30:0];
          frac <= {frac[FRAC_BITS-2:0], sq_bit};
          rnd  <= rnd + 1'b1;
          if (rnd == 5'(FRAC_BITS - 1)) begin
            if (!which) begin
              l1    <= log_val;
              which <= 1'b1;
              state <= S_LV2_MUL;
            end else begin
              dneg  <= d_c[LOG_W];
              dabs  <= d_c[LOG_W] ? (LOG_W + 1)'(-d_c) : d_c;
              state <= S_CD_LO;
            end
          end else begin
            state <= S_SQ_MUL;
          end
        end
        S_LV2_MUL: begin
          state <= S_LV_T;
        end
        S_CD_LO: begin
          state <= S_CD_ACC;
        end
        S_CD_ACC: begin
          acc   <= dneg ? acc - ACC_W'(p[31:0]) : acc + ACC_W'(p[31:0]);
          state <= S_CD_HI;
        end
        S_CD_HI: begin
          acc   <= dneg ? acc - (ACC_W'(p[31:0]) << 17) : acc + (ACC_W'(p[31:0]) << 17);
          state <= S_NEXT;
        end
        S_NEXT: begin
          if (ey == lim_m1) begin
            ey <= SLOT_W'(1);
            if (ex == lim_m1) begin
              state <= S_FIN;
            end else begin
              ex    <= ex + 1'b1;
              state <= S_T_RD;
            end
          end else begin
            ey    <= ey + 1'b1;
            state <= S_T_RD;
          end
        end
        S_FIN: begin
          state <= S_FIN_HI;
        end
        S_FIN_HI: begin
          num   <= NUM_W'(p) << 32;
          state <= S_FIN_LO;
        end
        S_FIN_LO: begin
          num   <= num + NUM_W'(p);
          state <= S_DIV_GO;
        end
        S_DIV_GO: begin
          state <= S_DIV;
        end
        S_DIV: begin
          if (div_done) begin
            if (|div_quo[NUM_W-1:36]) begin
              sc    <= NUM_W'(1) << 64;
              state <= S_RES;
            end else begin
              state <= S_SC_LO;
            end
          end
        end
        S_SC_LO: begin
          state <= S_SC_MID;
        end
        S_SC_MID: begin
          sc    <= NUM_W'(p) + (NUM_W'(1) << 31);
          state <= S_SC_HI;
        end
        S_SC_HI: begin
          sc    <= sc + (NUM_W'(p) << 32);
          state <= S_RES;
        end
        S_RES: begin
          mi_out  <= res_val;
          deg_out <= 1'b0;
          state   <= S_OUT;
        end
        S_OUT: begin
          if (res.ready) begin
            clr_addr  <= '0;
            row_total <= '0;
            gx        <= '0;
            gy        <= '0;
            state     <= S_CLEAR;
          end
        end
        default: begin
          state <= S_CLEAR;
        end
      endcase
    end
  end

  // channel outputs
  assign row.ready      = (state == S_IDLE);
  assign res.valid      = (state == S_OUT);
  assign res.mi_value   = mi_out;
  assign res.degenerate = deg_out;

  // a pending result holds off further rows
  assert property (@(posedge clk) disable iff (rst) res.valid |-> !row.ready)
    else $error("row accepted while result pending");

  // a degenerate result carries a zero value
  assert property (@(posedge clk) disable iff (rst)
    res.valid && res.degenerate |-> res.mi_value == '0)
    else $error("degenerate result with nonzero value");

  // gap counts never exceed the row count, which stays within capacity
  assert property (@(posedge clk) disable iff (rst)
    gx <= row_total && gy <= row_total && 32'(row_total) <= MAX_ROWS)
    else $error("row or gap count out of range");

  // a delivered result is followed by the clearing pass
  assert property (@(posedge clk) disable iff (rst)
    res.valid && res.ready |=> !res.valid && !row.ready)
    else $error("no clearing pass after result");

endmodule
